FILE: hdl/iir3lp_pkg.sv
// Shared types and constants for the third-order IIR low-pass filter.
// Used by the coefficient registers, both datapath stages and the top level.
package iir3lp_pkg;

  // Default widths, handed to the top level as parameter defaults
  localparam int SampleBitsDefault   = 16;
  localparam int CoefFracBitsDefault = 28;

  // Coefficient word and the headroom of the history format over the sample format
  localparam int CoefBits     = 32;
  localparam int HistGuard    = 8;
  localparam int CfgIndexBits = 3;

  typedef logic signed [CoefBits-1:0] coef_t;

  // Full coefficient set: four feed-forward taps, three feedback taps
  typedef struct packed {
    coef_t x0;
    coef_t x1;
    coef_t x2;
    coef_t x3;
    coef_t y1;
    coef_t y2;
    coef_t y3;
  } coef_set_t;

  // Register indexes on the configuration port
  localparam logic [CfgIndexBits-1:0] CfgX0 = 3'd0;
  localparam logic [CfgIndexBits-1:0] CfgX1 = 3'd1;
  localparam logic [CfgIndexBits-1:0] CfgX2 = 3'd2;
  localparam logic [CfgIndexBits-1:0] CfgX3 = 3'd3;
  localparam logic [CfgIndexBits-1:0] CfgY1 = 3'd4;
  localparam logic [CfgIndexBits-1:0] CfgY2 = 3'd5;
  localparam logic [CfgIndexBits-1:0] CfgY3 = 3'd6;

  // Reset coefficients: Butterworth low-pass, Q4.28
  localparam coef_t CoefX0Reset = 32'sd5867;
  localparam coef_t CoefX1Reset = 32'sd17601;
  localparam coef_t CoefX2Reset = 32'sd17601;
  localparam coef_t CoefX3Reset = 32'sd5867;
  localparam coef_t CoefY1Reset = 32'sd774722193;
  localparam coef_t CoefY2Reset = -32'sd745855552;
  localparam coef_t CoefY3Reset = 32'sd239521879;

  // Control of the feed-forward stage register, seen by the feedback stage
  typedef struct packed {
    logic valid;
    logic last;
  } s1_ctrl_t;

endpackage

FILE: hdl/iir3lp_ifs.sv
// Valid/ready channel interfaces for the filter's sample input and sample output.
// Depends on nothing but its parameter.
interface iir3lp_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic                          last_of_signal;

  modport source (output valid, output sample_in, output last_of_signal, input ready);
  modport sink   (input valid, input sample_in, input last_of_signal, output ready);
endinterface

interface iir3lp_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

FILE: hdl/iir3lp_coef_regs.sv
// Coefficient register file written through the plain configuration port.
// Depends on iir3lp_pkg for the coefficient types, indexes and reset values.
module iir3lp_coef_regs (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [iir3lp_pkg::CfgIndexBits-1:0]   cfg_index,
  input  logic [iir3lp_pkg::CoefBits-1:0]       cfg_data,
  output iir3lp_pkg::coef_set_t                 coefs
);

  // One register per index; writes past the last index fall through
  always_ff @(posedge clk) begin
    if (rst) begin
      coefs.x0 <= iir3lp_pkg::CoefX0Reset;
      coefs.x1 <= iir3lp_pkg::CoefX1Reset;
      coefs.x2 <= iir3lp_pkg::CoefX2Reset;
      coefs.x3 <= iir3lp_pkg::CoefX3Reset;
      coefs.y1 <= iir3lp_pkg::CoefY1Reset;
      coefs.y2 <= iir3lp_pkg::CoefY2Reset;
      coefs.y3 <= iir3lp_pkg::CoefY3Reset;
    end else if (cfg_write) begin
      case (cfg_index)
        iir3lp_pkg::CfgX0: coefs.x0 <= cfg_data;
        iir3lp_pkg::CfgX1: coefs.x1 <= cfg_data;
        iir3lp_pkg::CfgX2: coefs.x2 <= cfg_data;
        iir3lp_pkg::CfgX3: coefs.x3 <= cfg_data;
        iir3lp_pkg::CfgY1: coefs.y1 <= cfg_data;
        iir3lp_pkg::CfgY2: coefs.y2 <= cfg_data;
        iir3lp_pkg::CfgY3: coefs.y3 <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/iir3lp_ff_stage.sv
// Feed-forward stage: input history and the four input-tap products, summed into a register.
// Depends on iir3lp_pkg and the iir3lp_in_if interface.
module iir3lp_ff_stage #(
  parameter int SAMPLE_BITS    = iir3lp_pkg::SampleBitsDefault,
  parameter int COEF_FRAC_BITS = iir3lp_pkg::CoefFracBitsDefault,
  localparam int AccBits = iir3lp_pkg::CoefBits + SAMPLE_BITS + iir3lp_pkg::HistGuard + 3
) (
  input  logic                        clk,
  input  logic                        rst,
  input  iir3lp_pkg::coef_set_t       coefs,
  iir3lp_in_if.sink                   din,
  input  logic                        advance,
  output iir3lp_pkg::s1_ctrl_t        s1,
  output logic signed [AccBits-1:0]   ff_sum
);

  localparam int ProdBits = iir3lp_pkg::CoefBits + SAMPLE_BITS;
  localparam logic signed [AccBits-1:0] RoundBias = AccBits'(1) << (COEF_FRAC_BITS - 1);

  logic signed [SAMPLE_BITS-1:0] x_hist [3];
  logic signed [ProdBits-1:0]    p0, p1, p2, p3;
  logic signed [AccBits-1:0]     tap_sum;
  logic signed [AccBits-1:0]     ff_sum_next;
  logic                          accept;

  // Stage accepts when empty or when its content moves on this cycle
  assign din.ready = !s1.valid || advance;
  assign accept    = din.valid && din.ready;

  // Input taps; the x256 widening to the history format is a shift of the sum
  assign p0 = $signed(coefs.x0) * din.sample_in;
  assign p1 = $signed(coefs.x1) * x_hist[0];
  assign p2 = $signed(coefs.x2) * x_hist[1];
  assign p3 = $signed(coefs.x3) * x_hist[2];

  assign tap_sum = AccBits'(p0) + AccBits'(p1) + AccBits'(p2) + AccBits'(p3);
  assign ff_sum_next = (tap_sum <<< iir3lp_pkg::HistGuard) + RoundBias;

  // Stage register control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
      s1.last  <= 1'b0;
    end else if (accept) begin
      s1.valid <= 1'b1;
      s1.last  <= din.last_of_signal;
    end else if (advance) begin
      s1.valid <= 1'b0;
    end
  end

  // Partial sum, rounding bias already folded in
  always_ff @(posedge clk) begin
    if (accept) begin
      ff_sum <= ff_sum_next;
    end
  end

  // Input history; cleared after the last sample of a signal
  always_ff @(posedge clk) begin
    if (rst) begin
      x_hist[0] <= '0;
      x_hist[1] <= '0;
      x_hist[2] <= '0;
    end else if (accept) begin
      if (din.last_of_signal) begin
        x_hist[0] <= '0;
        x_hist[1] <= '0;
        x_hist[2] <= '0;
      end else begin
        x_hist[0] <= din.sample_in;
        x_hist[1] <= x_hist[0];
        x_hist[2] <= x_hist[1];
      end
    end
  end

endmodule

FILE: hdl/iir3lp_fb_stage.sv
// Feedback stage: output history taps, final sum, rounding, saturation and the output register.
// Depends on iir3lp_pkg and the iir3lp_out_if interface.
module iir3lp_fb_stage #(
  parameter int SAMPLE_BITS    = iir3lp_pkg::SampleBitsDefault,
  parameter int COEF_FRAC_BITS = iir3lp_pkg::CoefFracBitsDefault,
  localparam int AccBits = iir3lp_pkg::CoefBits + SAMPLE_BITS + iir3lp_pkg::HistGuard + 3
) (
  input  logic                        clk,
  input  logic                        rst,
  input  iir3lp_pkg::coef_set_t       coefs,
  input  iir3lp_pkg::s1_ctrl_t        s1,
  input  logic signed [AccBits-1:0]   ff_sum,
  output logic                        advance,
  iir3lp_out_if.source                dout
);

  localparam int HistBits = SAMPLE_BITS + iir3lp_pkg::HistGuard;
  localparam int ProdBits = iir3lp_pkg::CoefBits + HistBits;
  localparam logic signed [AccBits-1:0] HistMax =
    $signed({{(AccBits-HistBits+1){1'b0}}, {(HistBits-1){1'b1}}});
  localparam logic signed [AccBits-1:0] HistMin = ~HistMax;

  logic signed [HistBits-1:0] y_hist [3];
  logic signed [ProdBits-1:0] q1, q2, q3;
  logic signed [AccBits-1:0]  acc;
  logic signed [AccBits-1:0]  acc_q;
  logic signed [HistBits-1:0] y;

  // Load the output register when it is empty or being taken
  assign advance = s1.valid && (!dout.valid || dout.ready);

  // Feedback taps on the previous outputs
  assign q1 = $signed(coefs.y1) * y_hist[0];
  assign q2 = $signed(coefs.y2) * y_hist[1];
  assign q3 = $signed(coefs.y3) * y_hist[2];

  assign acc   = ff_sum + AccBits'(q1) + AccBits'(q2) + AccBits'(q3);
  assign acc_q = acc >>> COEF_FRAC_BITS;

  // Clamp to plus or minus one in Q1.23
  always_comb begin
    if (acc_q > HistMax) begin
      y = HistMax[HistBits-1:0];
    end else if (acc_q < HistMin) begin
      y = HistMin[HistBits-1:0];
    end else begin
      y = acc_q[HistBits-1:0];
    end
  end

  // Output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (advance) begin
      dout.valid <= 1'b1;
    end else if (dout.ready) begin
      dout.valid <= 1'b0;
    end
  end

  // Output sample: history value floored by 8 bits
  always_ff @(posedge clk) begin
    if (advance) begin
      dout.sample_out <= y[HistBits-1:iir3lp_pkg::HistGuard];
    end
  end

  // Output history; cleared after the last sample of a signal
  always_ff @(posedge clk) begin
    if (rst) begin
      y_hist[0] <= '0;
      y_hist[1] <= '0;
      y_hist[2] <= '0;
    end else if (advance) begin
      if (s1.last) begin
        y_hist[0] <= '0;
        y_hist[1] <= '0;
        y_hist[2] <= '0;
      end else begin
        y_hist[0] <= y;
        y_hist[1] <= y_hist[0];
        y_hist[2] <= y_hist[1];
      end
    end
  end

endmodule

FILE: hdl/third_order_iir_lowpass_top.sv
// Third-order IIR low-pass filter (direct form I) on a valid/ready sample stream. One result
// request leaves for each input request, and a new sample is taken every cycle unless the
// output stalls: the feed-forward taps are summed in the first register stage, and the three
// feedback taps, the Q1.23 rounding and the saturation to plus or minus one finish in the
// second, whose output history closes the recursion. Q4.28 coefficients are written on the
// configuration port at indexes 0 to 6 (x0, x1, x2, x3, y1, y2, y3); the user must write them
// only while idle (the block does not check). A request marked last clears both histories after
// it is filtered. Depends on iir3lp_pkg, the channel interfaces and the iir3lp_* submodules.
module third_order_iir_lowpass_top #(
  parameter int SAMPLE_BITS    = iir3lp_pkg::SampleBitsDefault,
  parameter int COEF_FRAC_BITS = iir3lp_pkg::CoefFracBitsDefault
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [iir3lp_pkg::CfgIndexBits-1:0] cfg_index,
  input  logic [iir3lp_pkg::CoefBits-1:0]     cfg_data,
  iir3lp_in_if.sink                           din,
  iir3lp_out_if.source                        dout
);

  localparam int AccBits = iir3lp_pkg::CoefBits + SAMPLE_BITS + iir3lp_pkg::HistGuard + 3;

  iir3lp_pkg::coef_set_t      coefs;
  iir3lp_pkg::s1_ctrl_t       s1;
  logic signed [AccBits-1:0]  ff_sum;
  logic                       advance;

  // Coefficient registers
  iir3lp_coef_regs u_coef_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coefs     (coefs)
  );

  // Input taps
  iir3lp_ff_stage #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_ff_stage (
    .clk     (clk),
    .rst     (rst),
    .coefs   (coefs),
    .din     (din),
    .advance (advance),
    .s1      (s1),
    .ff_sum  (ff_sum)
  );

  // Feedback taps and output register
  iir3lp_fb_stage #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_fb_stage (
    .clk     (clk),
    .rst     (rst),
    .coefs   (coefs),
    .s1      (s1),
    .ff_sum  (ff_sum),
    .advance (advance),
    .dout    (dout)
  );

endmodule
